// ===== rtl/core/atsd_pkg.sv =====
// Shared types, register codes, reset values and arithmetic helpers of the tilt/shake core.
`default_nettype none
package atsd_pkg;

   localparam int unsigned CSR_IDX_W = 3;
   localparam int unsigned SMOOTH_W  = 25;
   localparam int unsigned NUM_W     = 28;
   localparam int unsigned MAG_W     = 27;
   localparam int unsigned PROD_W    = MAG_W + NUM_W;
   localparam int unsigned RECIP_SH  = 30;

   // ceil(2^30 / 5); exact quotient for any magnitude below 2^30
   localparam logic [NUM_W-1:0] RECIP_5 = 28'd214748365;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ENABLED    = 3'd0,
      CSR_POLL       = 3'd1,
      CSR_SHAKE_THR  = 3'd2,
      CSR_TILT_LIMIT = 3'd3,
      CSR_DIZZY      = 3'd4
   } csr_idx_type;

   localparam logic        RST_ENABLED    = 1'b0;
   localparam logic [15:0] RST_POLL       = 16'd50;
   localparam logic [31:0] RST_SHAKE_THR  = 32'd20300431;
   localparam logic [6:0]  RST_TILT_LIMIT = 7'd10;
   localparam logic [15:0] RST_DIZZY      = 16'd2000;

   typedef struct packed {
      logic        enabled;
      logic [15:0] poll_interval_ms;
      logic [31:0] shake_threshold_sq;
      logic [6:0]  tilt_limit;
      logic [15:0] dizzy_duration_ms;
   } cfg_type;

   // captured sample plus its precomputed squared magnitude
   typedef struct packed {
      logic [31:0]        now_ms;
      logic               read_ok;
      logic signed [15:0] accel_x;
      logic signed [15:0] accel_y;
      logic [31:0]        mag_sq;
   } sample_type;

   // decision and fresh smoothed values, ahead of the tilt stage
   typedef struct packed {
      logic                       accepted;
      logic                       shake;
      logic [31:0]                dizzy_until_ms;
      logic                       tilt_valid;
      logic signed [SMOOTH_W-1:0] smooth_x;
      logic signed [SMOOTH_W-1:0] smooth_y;
   } decision_type;

   // (4*old + 256*sample) / 5, truncated toward zero
   function automatic logic signed [SMOOTH_W-1:0] smooth_step(
      input logic signed [SMOOTH_W-1:0] old_val,
      input logic signed [15:0]         sample
   );
      logic signed [NUM_W-1:0] num;
      logic [NUM_W-1:0]        mag;
      logic [PROD_W-1:0]       prod;
      logic [SMOOTH_W-1:0]     quo;
      num  = $signed({old_val[SMOOTH_W-1], old_val, 2'b00})
           + $signed({{4{sample[15]}}, sample, 8'h00});
      mag  = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
      prod = PROD_W'(mag[MAG_W-1:0]) * PROD_W'(RECIP_5);
      quo  = prod[RECIP_SH +: SMOOTH_W];
      return num[NUM_W-1] ? $signed(SMOOTH_W'(-quo)) : $signed(quo);
   endfunction

   function automatic logic signed [7:0] tilt_clamp(
      input logic signed [8:0] val,
      input logic [6:0]        lim
   );
      logic signed [8:0] lim_pos;
      logic signed [8:0] lim_neg;
      lim_pos = $signed({2'b00, lim});
      lim_neg = -lim_pos;
      if (val > lim_pos) begin
         return lim_pos[7:0];
      end else if (val < lim_neg) begin
         return lim_neg[7:0];
      end
      return val[7:0];
   endfunction

endpackage
`default_nettype wire

// ===== rtl/core/atsd_csr.sv =====
// Configuration register file of the tilt/shake core.
`default_nettype none
module atsd_csr (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               csr_valid,
   output      logic                               csr_ready,
   input  wire logic [atsd_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [31:0]                        csr_wdata,
   output      atsd_pkg::cfg_type                  cfg
);
   import atsd_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_ENABLED:    cfg_in.enabled            = csr_wdata[0];
            CSR_POLL:       cfg_in.poll_interval_ms   = csr_wdata[15:0];
            CSR_SHAKE_THR:  cfg_in.shake_threshold_sq = csr_wdata;
            CSR_TILT_LIMIT: cfg_in.tilt_limit         = csr_wdata[6:0];
            CSR_DIZZY:      cfg_in.dizzy_duration_ms  = csr_wdata[15:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.enabled            <= RST_ENABLED;
         cfg_ff.poll_interval_ms   <= RST_POLL;
         cfg_ff.shake_threshold_sq <= RST_SHAKE_THR;
         cfg_ff.tilt_limit         <= RST_TILT_LIMIT;
         cfg_ff.dizzy_duration_ms  <= RST_DIZZY;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/core/atsd_sample_reg.sv =====
// Input stage: captures a sample and registers its sum of squared axes.
`default_nettype none
module atsd_sample_reg (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output      logic                 req_ready,
   input  wire logic [31:0]          req_now_ms,
   input  wire logic                 req_read_ok,
   input  wire logic signed [15:0]   req_accel_x,
   input  wire logic signed [15:0]   req_accel_y,
   input  wire logic signed [15:0]   req_accel_z,
   output      logic                 smp_valid,
   input  wire logic                 smp_ready,
   output      atsd_pkg::sample_type smp
);
   import atsd_pkg::*;

   logic        valid_ff;
   logic        valid_in;
   sample_type  smp_ff;
   sample_type  smp_in;
   logic signed [31:0] sq_x;
   logic signed [31:0] sq_y;
   logic signed [31:0] sq_z;
   logic        load;

   assign req_ready = !valid_ff || smp_ready;
   assign load      = req_valid && req_ready;
   assign smp_valid = valid_ff;
   assign smp       = smp_ff;

   // each square is at most 2^30, so the three fit 32 bits unsigned
   assign sq_x = req_accel_x * req_accel_x;
   assign sq_y = req_accel_y * req_accel_y;
   assign sq_z = req_accel_z * req_accel_z;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (smp_ready) begin
         valid_in = 1'b0;
      end
      smp_in.now_ms  = req_now_ms;
      smp_in.read_ok = req_read_ok;
      smp_in.accel_x = req_accel_x;
      smp_in.accel_y = req_accel_y;
      smp_in.mag_sq  = $unsigned(sq_x) + $unsigned(sq_y) + $unsigned(sq_z);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         smp_ff <= smp_in;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/core/atsd_state_update.sv =====
// Decision stage: gating, shake test and smoothing, with the persistent state.
`default_nettype none
module atsd_state_update (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire atsd_pkg::cfg_type      cfg,
   input  wire logic                   smp_valid,
   output      logic                   smp_ready,
   input  wire atsd_pkg::sample_type   smp,
   output      logic                   dec_valid,
   input  wire logic                   dec_ready,
   output      atsd_pkg::decision_type dec
);
   import atsd_pkg::*;

   logic                       valid_ff;
   logic                       valid_in;
   decision_type               dec_ff;
   decision_type               dec_in;
   logic [31:0]                last_poll_ff;
   logic [31:0]                last_poll_in;
   logic signed [SMOOTH_W-1:0] smooth_x_ff;
   logic signed [SMOOTH_W-1:0] smooth_x_in;
   logic signed [SMOOTH_W-1:0] smooth_y_ff;
   logic signed [SMOOTH_W-1:0] smooth_y_in;
   logic                       move;
   logic [31:0]                gap;
   logic                       taken;
   logic                       shake;
   logic                       tilt_ok;

   assign smp_ready = !valid_ff || dec_ready;
   assign move      = smp_valid && smp_ready;
   assign dec_valid = valid_ff;
   assign dec       = dec_ff;

   always_comb begin
      gap     = smp.now_ms - last_poll_ff;
      taken   = cfg.enabled && (gap >= 32'(cfg.poll_interval_ms));
      shake   = taken && smp.read_ok && (smp.mag_sq > cfg.shake_threshold_sq);
      tilt_ok = taken && smp.read_ok && !shake;

      last_poll_in = last_poll_ff;
      smooth_x_in  = smooth_x_ff;
      smooth_y_in  = smooth_y_ff;
      if (move && taken) begin
         last_poll_in = smp.now_ms;
      end
      if (move && tilt_ok) begin
         smooth_x_in = smooth_step(smooth_x_ff, smp.accel_x);
         smooth_y_in = smooth_step(smooth_y_ff, smp.accel_y);
      end

      dec_in.accepted       = taken && smp.read_ok;
      dec_in.shake          = shake;
      dec_in.dizzy_until_ms = shake ? smp.now_ms + 32'(cfg.dizzy_duration_ms) : 32'd0;
      dec_in.tilt_valid     = tilt_ok;
      dec_in.smooth_x       = smooth_x_in;
      dec_in.smooth_y       = smooth_y_in;

      valid_in = valid_ff;
      if (move) begin
         valid_in = 1'b1;
      end else if (dec_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= 1'b0;
         last_poll_ff <= '0;
         smooth_x_ff  <= '0;
         smooth_y_ff  <= '0;
      end else begin
         valid_ff     <= valid_in;
         last_poll_ff <= last_poll_in;
         smooth_x_ff  <= smooth_x_in;
         smooth_y_ff  <= smooth_y_in;
      end
   end

   always_ff @(posedge clock) begin
      if (move) begin
         dec_ff <= dec_in;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/core/atsd_tilt_out.sv =====
// Output stage: scales and clamps the smoothed values into tilt offsets.
`default_nettype none
module atsd_tilt_out (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic [6:0]             tilt_limit,
   input  wire logic                   dec_valid,
   output      logic                   dec_ready,
   input  wire atsd_pkg::decision_type dec,
   output      logic                   rsp_valid,
   input  wire logic                   rsp_ready,
   output      logic                   rsp_accepted,
   output      logic                   rsp_shake,
   output      logic [31:0]            rsp_dizzy_until_ms,
   output      logic                   rsp_tilt_valid,
   output      logic signed [7:0]      rsp_tilt_x,
   output      logic signed [7:0]      rsp_tilt_y
);
   import atsd_pkg::*;

   logic                       valid_ff;
   logic                       valid_in;
   logic                       accepted_ff;
   logic                       shake_ff;
   logic [31:0]                dizzy_ff;
   logic                       tilt_valid_ff;
   logic signed [7:0]          tilt_x_ff;
   logic signed [7:0]          tilt_x_in;
   logic signed [7:0]          tilt_y_ff;
   logic signed [7:0]          tilt_y_in;
   logic                       load;
   logic signed [SMOOTH_W-1:0] sx_biased;
   logic signed [SMOOTH_W+1:0] sy_wide;
   logic signed [SMOOTH_W+1:0] py;
   logic signed [SMOOTH_W+1:0] py_biased;

   assign dec_ready = !valid_ff || rsp_ready;
   assign load      = dec_valid && dec_ready;

   always_comb begin
      // x: divide by 2^16 toward zero
      sx_biased = dec.smooth_x + $signed({9'd0, {16{dec.smooth_x[SMOOTH_W-1]}}});
      // y: -3 * smooth_y, divide by 2^18 toward zero
      sy_wide   = {{2{dec.smooth_y[SMOOTH_W-1]}}, dec.smooth_y};
      py        = -(sy_wide + (sy_wide <<< 1));
      py_biased = py + $signed({9'd0, {18{py[SMOOTH_W+1]}}});

      tilt_x_in = '0;
      tilt_y_in = '0;
      if (dec.tilt_valid) begin
         tilt_x_in = tilt_clamp($signed(sx_biased[SMOOTH_W-1:16]), tilt_limit);
         tilt_y_in = tilt_clamp($signed(py_biased[SMOOTH_W+1:18]), tilt_limit);
      end

      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         accepted_ff   <= dec.accepted;
         shake_ff      <= dec.shake;
         dizzy_ff      <= dec.dizzy_until_ms;
         tilt_valid_ff <= dec.tilt_valid;
         tilt_x_ff     <= tilt_x_in;
         tilt_y_ff     <= tilt_y_in;
      end
   end

   assign rsp_valid          = valid_ff;
   assign rsp_accepted       = accepted_ff;
   assign rsp_shake          = shake_ff;
   assign rsp_dizzy_until_ms = dizzy_ff;
   assign rsp_tilt_valid     = tilt_valid_ff;
   assign rsp_tilt_x         = tilt_x_ff;
   assign rsp_tilt_y         = tilt_y_ff;

endmodule
`default_nettype wire

// ===== rtl/core/accel_tilt_and_shake_detector_core.sv =====
// Top level of the accelerometer tilt smoother and shake detector.
// Every sample item yields exactly one result item, in order. A sample is taken
// when enabled and at least poll_interval_ms (mod 2^32) after the last taken
// time; a taken time is remembered even when read_ok is low. A good read whose
// sum of squared axes is above shake_threshold_sq reports a shake with deadline
// now_ms + dizzy_duration_ms; otherwise X/Y are smoothed (x8 fraction bits,
// new = (4*old + 256*sample)/5) and tilt offsets are clamped to +/-tilt_limit.
// Throughput is one item per clock while rsp_ready is high; items pass
// through the sample register, the decision/state register and the result
// register. The loop on the smoothing state (a 27x28 reciprocal multiply for
// the divide by five) is what bounds the clock. Stages stall independently,
// so a held result does not block intake until all three stages are full.
// Config writes take effect the next cycle; csr_ready is always high. Write
// them only while no item is in flight.
`default_nettype none
module accel_tilt_and_shake_detector_core (
   input  wire logic                           clock,
   input  wire logic                           reset,
   // sample items
   input  wire logic                           req_valid,
   output      logic                           req_ready,
   input  wire logic [31:0]                    req_now_ms,
   input  wire logic                           req_read_ok,
   input  wire logic signed [15:0]             req_accel_x,
   input  wire logic signed [15:0]             req_accel_y,
   input  wire logic signed [15:0]             req_accel_z,
   // result items
   output      logic                           rsp_valid,
   input  wire logic                           rsp_ready,
   output      logic                           rsp_accepted,
   output      logic                           rsp_shake,
   output      logic [31:0]                    rsp_dizzy_until_ms,
   output      logic                           rsp_tilt_valid,
   output      logic signed [7:0]              rsp_tilt_x,
   output      logic signed [7:0]              rsp_tilt_y,
   // register writes
   input  wire logic                           csr_valid,
   output      logic                           csr_ready,
   input  wire logic [atsd_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [31:0]                    csr_wdata
);
   import atsd_pkg::*;

   cfg_type      cfg;
   logic         smp_valid;
   logic         smp_ready;
   sample_type   smp;
   logic         dec_valid;
   logic         dec_ready;
   decision_type dec;

   atsd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // stage 1: capture, squares summed ahead of the state loop
   atsd_sample_reg u_sample (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_now_ms  (req_now_ms),
      .req_read_ok (req_read_ok),
      .req_accel_x (req_accel_x),
      .req_accel_y (req_accel_y),
      .req_accel_z (req_accel_z),
      .smp_valid   (smp_valid),
      .smp_ready   (smp_ready),
      .smp         (smp)
   );

   // stage 2: interval gate, shake compare, smoothing; owns the state
   atsd_state_update u_update (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .smp_valid (smp_valid),
      .smp_ready (smp_ready),
      .smp       (smp),
      .dec_valid (dec_valid),
      .dec_ready (dec_ready),
      .dec       (dec)
   );

   // stage 3: scale, clamp, result register
   atsd_tilt_out u_tilt (
      .clock              (clock),
      .reset              (reset),
      .tilt_limit         (cfg.tilt_limit),
      .dec_valid          (dec_valid),
      .dec_ready          (dec_ready),
      .dec                (dec),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_accepted       (rsp_accepted),
      .rsp_shake          (rsp_shake),
      .rsp_dizzy_until_ms (rsp_dizzy_until_ms),
      .rsp_tilt_valid     (rsp_tilt_valid),
      .rsp_tilt_x         (rsp_tilt_x),
      .rsp_tilt_y         (rsp_tilt_y)
   );

endmodule
`default_nettype wire

// ===== dv/accel_tilt_and_shake_detector_core_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for the tilt/shake core: mirrors its state, predicts every result item and compares.
module accel_tilt_and_shake_detector_core_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_ready,
   input  logic [31:0]                    req_now_ms,
   input  logic                           req_read_ok,
   input  logic signed [15:0]             req_accel_x,
   input  logic signed [15:0]             req_accel_y,
   input  logic signed [15:0]             req_accel_z,
   input  logic                           rsp_valid,
   input  logic                           rsp_ready,
   input  logic                           rsp_accepted,
   input  logic                           rsp_shake,
   input  logic [31:0]                    rsp_dizzy_until_ms,
   input  logic                           rsp_tilt_valid,
   input  logic signed [7:0]              rsp_tilt_x,
   input  logic signed [7:0]              rsp_tilt_y,
   input  logic                           csr_valid,
   input  logic                           csr_ready,
   input  logic [atsd_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]                    csr_wdata,
   output int unsigned                    mismatches,
   output int unsigned                    results_pending
);
   import atsd_pkg::*;

   typedef struct packed {
      logic               accepted;
      logic               shake;
      logic [31:0]        dizzy_until_ms;
      logic               tilt_valid;
      logic signed [7:0]  tilt_x;
      logic signed [7:0]  tilt_y;
   } tilt_verdict_type;

   tilt_verdict_type awaited_verdicts[$];

   // mirrored registers
   logic        en_q;
   logic [15:0] poll_q;
   logic [31:0] thr_q;
   logic [6:0]  lim_q;
   logic [15:0] dizzy_q;

   // mirrored state
   logic [31:0]        last_taken_ms;
   logic signed [24:0] avg_x;
   logic signed [24:0] avg_y;

   int unsigned error_total = 0;

   function automatic logic signed [7:0] limit_offset(input longint v);
      longint lim;
      lim = {57'd0, lim_q};
      if (v > lim) return 8'(lim);
      if (v < -lim) return 8'(-lim);
      return 8'(v);
   endfunction

   // advances the mirrored state by one sample and returns the result it should give
   function automatic tilt_verdict_type judge_sample(
      input logic [31:0]        now,
      input logic               ok,
      input logic signed [15:0] ax,
      input logic signed [15:0] ay,
      input logic signed [15:0] az
   );
      tilt_verdict_type r;
      logic [31:0]      since;
      longint           mag_sq;
      longint           thr_wide;
      longint           nx;
      longint           ny;
      r = '0;
      if (!en_q) return r;
      since = now - last_taken_ms;
      if (since < {16'd0, poll_q}) return r;
      last_taken_ms = now;
      if (!ok) return r;
      r.accepted = 1'b1;
      mag_sq = longint'(ax) * longint'(ax) + longint'(ay) * longint'(ay)
             + longint'(az) * longint'(az);
      thr_wide = {32'd0, thr_q};
      if (mag_sq > thr_wide) begin
         r.shake = 1'b1;
         r.dizzy_until_ms = now + {16'd0, dizzy_q};
         return r;
      end
      nx = (4 * longint'(avg_x) + 256 * longint'(ax)) / 5;
      ny = (4 * longint'(avg_y) + 256 * longint'(ay)) / 5;
      avg_x = 25'(nx);
      avg_y = 25'(ny);
      r.tilt_valid = 1'b1;
      r.tilt_x = limit_offset(longint'(avg_x) / 65536);
      r.tilt_y = limit_offset((-3 * longint'(avg_y)) / 262144);
      return r;
   endfunction

   task automatic report_mismatch(input string what);
      if (error_total < 200) $display("MISMATCH at %0t: %s", $time, what);
      error_total++;
   endtask

   always @(posedge clock) begin
      tilt_verdict_type want;
      if (reset) begin
         en_q = RST_ENABLED;
         poll_q = RST_POLL;
         thr_q = RST_SHAKE_THR;
         lim_q = RST_TILT_LIMIT;
         dizzy_q = RST_DIZZY;
         last_taken_ms = '0;
         avg_x = '0;
         avg_y = '0;
         awaited_verdicts.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (awaited_verdicts.size() == 0) begin
               report_mismatch("result item with no sample waiting for it");
            end else begin
               want = awaited_verdicts.pop_front();
               if (rsp_accepted !== want.accepted)
                  report_mismatch($sformatf("accepted: got %0b, expected %0b",
                                            rsp_accepted, want.accepted));
               if (rsp_shake !== want.shake)
                  report_mismatch($sformatf("shake: got %0b, expected %0b",
                                            rsp_shake, want.shake));
               if (rsp_dizzy_until_ms !== want.dizzy_until_ms)
                  report_mismatch($sformatf("dizzy_until_ms: got %0h, expected %0h",
                                            rsp_dizzy_until_ms, want.dizzy_until_ms));
               if (rsp_tilt_valid !== want.tilt_valid)
                  report_mismatch($sformatf("tilt_valid: got %0b, expected %0b",
                                            rsp_tilt_valid, want.tilt_valid));
               if (rsp_tilt_x !== want.tilt_x)
                  report_mismatch($sformatf("tilt_x: got %0d, expected %0d",
                                            rsp_tilt_x, want.tilt_x));
               if (rsp_tilt_y !== want.tilt_y)
                  report_mismatch($sformatf("tilt_y: got %0d, expected %0d",
                                            rsp_tilt_y, want.tilt_y));
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_ENABLED:    en_q = csr_wdata[0];
               CSR_POLL:       poll_q = csr_wdata[15:0];
               CSR_SHAKE_THR:  thr_q = csr_wdata;
               CSR_TILT_LIMIT: lim_q = csr_wdata[6:0];
               CSR_DIZZY:      dizzy_q = csr_wdata[15:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready)
            awaited_verdicts.push_back(judge_sample(req_now_ms, req_read_ok, req_accel_x,
                                                    req_accel_y, req_accel_z));
      end
      mismatches <= error_total;
      results_pending <= awaited_verdicts.size();
   end

endmodule

// ===== dv/accel_tilt_and_shake_detector_core_tb.sv =====
`timescale 1ns / 1ps
// Testbench top for the tilt/shake core: sample and register stimulus, flow control, verdict.
module accel_tilt_and_shake_detector_core_tb;
   import atsd_pkg::*;

   localparam int unsigned LONG_HOLD     = 300;   // receiver hold-off, long enough to fill the pipe
   localparam int unsigned STALL_LIMIT   = 5000;  // cycles without any handshake before giving up
   localparam int unsigned SETTLE_CYCLES = 10;    // idle margin before the final verdict
   localparam int unsigned PHASE_ITEMS   = 310;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;

   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [31:0]           req_now_ms = '0;
   logic                  req_read_ok = 1'b0;
   logic signed [15:0]    req_accel_x = '0;
   logic signed [15:0]    req_accel_y = '0;
   logic signed [15:0]    req_accel_z = '0;

   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic                  rsp_accepted;
   logic                  rsp_shake;
   logic [31:0]           rsp_dizzy_until_ms;
   logic                  rsp_tilt_valid;
   logic signed [7:0]     rsp_tilt_x;
   logic signed [7:0]     rsp_tilt_y;

   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [31:0]           csr_wdata = '0;

   int unsigned           mismatches;
   int unsigned           results_pending;

   // flow-control knobs, percent of cycles spent idle on each side
   int unsigned           req_idle_pct = 0;
   int unsigned           rsp_idle_pct = 0;

   // the stimulus bumps hold_requests; the receiver serves each one with a long hold-off
   int unsigned           hold_requests = 0;
   int unsigned           holds_served = 0;
   int unsigned           hold_left = 0;

   int unsigned           stall_cycles = 0;
   int unsigned           random_sent = 0;

   // stimulus-side notion of sensor time and of the current poll interval
   logic [31:0]           time_cursor = '0;
   logic [15:0]           poll_gap = RST_POLL;
   int                    posture_x = 0;
   int                    posture_y = 0;
   int                    posture_z = 0;

   accel_tilt_and_shake_detector_core dut (.*);

   accel_tilt_and_shake_detector_core_checker sb (.*);

   initial begin
      forever #1 clock = ~clock;
   end

   // Result side: random back-pressure, or a long solid hold-off when one is requested.
   always @(posedge clock) begin
      if (hold_left != 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (holds_served != hold_requests) begin
         holds_served <= holds_served + 1;
         hold_left <= LONG_HOLD;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= rsp_idle_pct);
      end
   end

   // Watchdog: any handshake on any channel counts as progress.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready))
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   function automatic logic signed [15:0] sat16(input int v);
      if (v > 32767) return 16'sd32767;
      if (v < -32768) return -16'sd32768;
      return 16'(v);
   endfunction

   // Offers one sample item, after a random idle gap, and returns at the edge it is taken.
   // Valid stays up between back-to-back items, so it is only lowered inside a gap.
   task automatic send_sample(
      input logic [31:0]        now,
      input logic               ok,
      input logic signed [15:0] ax,
      input logic signed [15:0] ay,
      input logic signed [15:0] az
   );
      while ($urandom_range(0, 99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_now_ms <= now;
      req_read_ok <= ok;
      req_accel_x <= ax;
      req_accel_y <= ay;
      req_accel_z <= az;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic put_csr(input csr_idx_type idx, input logic [31:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
   endtask

   // Writes all five registers; upper bits beyond a field's width are don't-care to the core.
   task automatic configure(
      input logic [31:0] en,
      input logic [31:0] poll,
      input logic [31:0] thr,
      input logic [31:0] lim,
      input logic [31:0] dizzy
   );
      put_csr(CSR_ENABLED, en);
      put_csr(CSR_POLL, poll);
      put_csr(CSR_SHAKE_THR, thr);
      put_csr(CSR_TILT_LIMIT, lim);
      put_csr(CSR_DIZZY, dizzy);
      csr_valid <= 1'b0;
      poll_gap = poll[15:0];
   endtask

   // Stops offering and waits until every predicted result has been seen.
   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (results_pending != 0);
   endtask

   // Idling schedule over the random part: sender light / receiver heavy,
   // then swapped, then both sides at full rate.
   task automatic set_idling();
      if (random_sent < 600) begin
         req_idle_pct = 24;
         rsp_idle_pct <= 72;
      end else if (random_sent < 1200) begin
         req_idle_pct = 72;
         rsp_idle_pct <= 24;
      end else begin
         req_idle_pct = 0;
         rsp_idle_pct <= 0;
      end
   endtask

   // Mostly well-spaced samples around a slowly moving posture, so the smoother
   // actually tracks something and the clamp gets hit; the rest are early
   // samples and raw noise with random time stamps.
   task automatic run_random(input int unsigned n, input int amp);
      int unsigned        i;
      int unsigned        kind;
      logic [31:0]        now;
      logic               ok;
      logic signed [15:0] ax;
      logic signed [15:0] ay;
      logic signed [15:0] az;
      for (i = 0; i < n; i++) begin
         set_idling();
         if (random_sent == 100 || random_sent == 900)
            hold_requests <= hold_requests + 1;
         if (i == 0 || $urandom_range(0, 39) == 0) begin
            posture_x = int'($urandom_range(0, 2 * amp)) - amp;
            posture_y = int'($urandom_range(0, 2 * amp)) - amp;
            posture_z = int'($urandom_range(0, 2 * amp)) - amp;
         end
         ax = sat16(posture_x + int'($urandom_range(0, 512)) - 256);
         ay = sat16(posture_y + int'($urandom_range(0, 512)) - 256);
         az = sat16(posture_z + int'($urandom_range(0, 512)) - 256);
         kind = $urandom_range(0, 99);
         if (kind < 8 && poll_gap != 0) begin
            // inside the poll window of the cursor: normally dropped
            now = time_cursor + $urandom_range(0, poll_gap - 1);
            ok = 1'b1;
         end else if (kind < 14) begin
            now = $urandom;
            time_cursor = now;
            ok = 1'($urandom_range(0, 1));
            ax = 16'($urandom);
            ay = 16'($urandom);
            az = 16'($urandom);
         end else begin
            time_cursor = time_cursor + poll_gap + $urandom_range(0, 40);
            now = time_cursor;
            ok = ($urandom_range(0, 9) != 0);
         end
         send_sample(now, ok, ax, ay, az);
         random_sent++;
      end
   endtask

   initial begin
      logic [31:0] cfg_en;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Out of reset the core is disabled: these must come back all zero.
      send_sample(32'd60, 1'b1, 16'sd100, -16'sd100, 16'sd100);
      send_sample(32'd70, 1'b1, 16'sd32767, -16'sd32768, 16'sd0);
      drain();

      // Default thresholds, now enabled.
      configure(1, RST_POLL, RST_SHAKE_THR, RST_TILT_LIMIT, RST_DIZZY);
      send_sample(32'd10, 1'b1, 16'sd0, 16'sd0, 16'sd0);              // too early
      send_sample(32'd50, 1'b1, 16'sd0, 16'sd0, 16'sd0);              // exactly one interval
      send_sample(32'd99, 1'b1, 16'sd500, 16'sd500, 16'sd0);          // too early
      send_sample(32'd100, 1'b0, 16'sd1000, 16'sd1000, 16'sd1000);    // failed read, time kept
      send_sample(32'd149, 1'b1, 16'sd1000, 16'sd1000, 16'sd1000);    // early vs the failed read
      send_sample(32'd150, 1'b1, 16'sd32767, -16'sd32768, -16'sd32768); // shake
      send_sample(32'd200, 1'b1, 16'sd2600, -16'sd2600, 16'sd2600);   // just under threshold
      // shake right before the time wrap: deadline wraps too
      send_sample(32'hFFFF_FFF0, 1'b1, 16'sd32767, 16'sd32767, 16'sd32767);
      send_sample(32'h0000_0021, 1'b1, 16'sd0, 16'sd0, 16'sd0);       // 49 ms across the wrap
      send_sample(32'h0000_0022, 1'b1, -16'sd2000, 16'sd2500, 16'sd100);
      drain();

      // No interval, no shake possible, widest clamp: drive the smoother to its extremes.
      configure(1, 0, 32'hFFFF_FFFF, 127, 32'h0000_FFFF);
      send_sample(32'd5, 1'b1, 16'sd32767, -16'sd32768, -16'sd32768);
      send_sample(32'd5, 1'b1, 16'sd32767, -16'sd32768, -16'sd32768);
      send_sample(32'd5, 1'b1, -16'sd32768, 16'sd32767, 16'sd32767);
      send_sample(32'd5, 1'b1, 16'sd0, 16'sd0, 16'sd0);
      drain();

      // Longest interval, threshold of one, zero clamp, zero dizzy time.
      configure(1, 32'h0000_FFFF, 1, 0, 0);
      send_sample(32'd65540, 1'b1, 16'sd1, 16'sd0, 16'sd0);   // sum equals threshold: no shake
      send_sample(32'd131075, 1'b1, 16'sd1, 16'sd1, 16'sd0);  // one above: shake
      send_sample(32'd196609, 1'b1, 16'sd0, 16'sd0, 16'sd0);  // one ms short
      drain();
      time_cursor = 32'd131075;

      // Random phases, each under its own register setting.
      configure(1, RST_POLL, RST_SHAKE_THR, RST_TILT_LIMIT, RST_DIZZY);
      run_random(PHASE_ITEMS, 3000);
      drain();
      configure(1, 0, 32'hFFFF_FFFF, 127, 32'h0000_FFFF);
      run_random(PHASE_ITEMS, 32767);
      drain();
      configure(0, RST_POLL, RST_SHAKE_THR, RST_TILT_LIMIT, RST_DIZZY);
      run_random(20, 3000);
      drain();
      configure(1, 32'h0000_FFFF, 0, 0, 0);
      run_random(PHASE_ITEMS, 2000);
      drain();
      configure(1, 1, 100000000, 64, 1234);
      run_random(PHASE_ITEMS, 6000);
      drain();
      // fully random words, including junk above each field; keep the core enabled
      cfg_en = $urandom;
      cfg_en[0] = 1'b1;
      configure(cfg_en, $urandom, $urandom, $urandom, $urandom);
      run_random(PHASE_ITEMS, 20000);
      drain();
      cfg_en = $urandom;
      cfg_en[0] = 1'b1;
      configure(cfg_en, $urandom_range(0, 200), $urandom, $urandom, $urandom);
      run_random(PHASE_ITEMS, 4000);
      drain();

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0 && results_pending == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/core/atsd_pkg.sv
rtl/core/atsd_csr.sv
rtl/core/atsd_sample_reg.sv
rtl/core/atsd_state_update.sv
rtl/core/atsd_tilt_out.sv
rtl/core/accel_tilt_and_shake_detector_core.sv
dv/accel_tilt_and_shake_detector_core_checker.sv
dv/accel_tilt_and_shake_detector_core_tb.sv
